// ----- rtl/glzw_pkg.sv -----
// ----------------------------------------------------------------------------
// glzw_pkg
// shared types and constants of the gif lzw pixel decoder
// ----------------------------------------------------------------------------
package glzw_pkg;

    localparam int TABLE_CODES   = 4096;
    localparam int MAX_CODE_BITS = 12;
    localparam int ADDR_W        = 12;
    localparam int DEPTH_W       = 13;

    // configuration register indexes
    localparam logic [7:0] CFG_MIN_CODE_SIZE = 8'd0;
    localparam logic [7:0] CFG_FRAME_WIDTH   = 8'd1;
    localparam logic [7:0] CFG_FRAME_HEIGHT  = 8'd2;
    localparam logic [7:0] CFG_INTERLACED    = 8'd3;

    // result status codes
    typedef enum logic [2:0] {
        ST_PIXEL     = 3'd0,
        ST_NEED_DATA = 3'd1,
        ST_FRAME_END = 3'd2,
        ST_BAD_CODE  = 3'd3,
        ST_TAKEN     = 3'd4,
        ST_REFUSED   = 3'd5
    } res_status_t;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_OFFER,
        CMD_CHECK,
        CMD_WALK_ADDR,
        CMD_WALK_DATA,
        CMD_ROOT,
        CMD_KWK,
        CMD_TABLE,
        CMD_EMIT
    } cmd_t;

    // outcome of a check step
    typedef enum logic [1:0] {
        CHK_DONE,
        CHK_PIXEL,
        CHK_AGAIN,
        CHK_WALK
    } chk_t;

    typedef struct packed {
        cmd_t cmd;
        logic take;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        chk_t chk;
        logic walk_read;
        logic walk_more;
        logic kwk;
    } dp_stat_t;

    function automatic logic [3:0] pass_first_row(input logic [1:0] pass);
        logic [3:0] r;
        unique case (pass)
            2'd0:    r = 4'd0;
            2'd1:    r = 4'd4;
            2'd2:    r = 4'd2;
            default: r = 4'd1;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] pass_row_step(input logic [1:0] pass);
        logic [3:0] r;
        unique case (pass)
            2'd0:    r = 4'd8;
            2'd1:    r = 4'd8;
            2'd2:    r = 4'd4;
            default: r = 4'd2;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/glzw_ctrl.sv -----
// ----------------------------------------------------------------------------
// glzw_ctrl
// sequencer that steps the datapath through one item at a time
// ----------------------------------------------------------------------------
module glzw_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               opcode,
    output logic               m_tvalid,
    input  logic               m_tready,
    output glzw_pkg::ctl_t     ctl,
    input  glzw_pkg::dp_stat_t stat
);
    import glzw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OFFER,
        S_CHECK,
        S_WALK_ADDR,
        S_WALK_DATA,
        S_ROOT,
        S_KWK,
        S_TABLE,
        S_RD_PIX,
        S_EMIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        ctl.cmd       = CMD_NONE;
        ctl.take      = 1'b0;
        ctl.out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.take   = 1'b1;
                    state_next = opcode ? S_CHECK : S_OFFER;
                end
            end
            S_OFFER:
            begin
                ctl.cmd    = CMD_OFFER;
                state_next = S_DONE;
            end
            S_CHECK:
            begin
                ctl.cmd = CMD_CHECK;
                unique case (stat.chk)
                    CHK_DONE:  state_next = S_DONE;
                    CHK_PIXEL: state_next = S_RD_PIX;
                    CHK_AGAIN: state_next = S_CHECK;
                    default:   state_next = S_WALK_ADDR;
                endcase
            end
            S_WALK_ADDR:
            begin
                ctl.cmd    = CMD_WALK_ADDR;
                state_next = stat.walk_read ? S_WALK_DATA : S_ROOT;
            end
            S_WALK_DATA:
            begin
                ctl.cmd    = CMD_WALK_DATA;
                state_next = stat.walk_more ? S_WALK_ADDR : S_ROOT;
            end
            S_ROOT:
            begin
                ctl.cmd    = CMD_ROOT;
                state_next = stat.kwk ? S_KWK : S_TABLE;
            end
            S_KWK:
            begin
                ctl.cmd    = CMD_KWK;
                state_next = S_TABLE;
            end
            S_TABLE:
            begin
                ctl.cmd    = CMD_TABLE;
                state_next = S_RD_PIX;
            end
            S_RD_PIX:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                ctl.cmd    = CMD_EMIT;
                state_next = S_DONE;
            end
            default:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    ctl.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ----- rtl/glzw_datapath.sv -----
// ----------------------------------------------------------------------------
// glzw_datapath
// bit buffer, string table, pixel stack and frame position registers
// ----------------------------------------------------------------------------
module glzw_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  glzw_pkg::ctl_t     ctl,
    output glzw_pkg::dp_stat_t stat,
    input  logic [7:0]         in_byte,
    input  logic               cfg_valid,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic [2:0]         status,
    output logic [7:0]         pixel_index,
    output logic [15:0]        column,
    output logic [15:0]        display_row,
    output logic               row_end
);
    import glzw_pkg::*;

    // configuration
    logic [3:0]  min_size_reg;
    logic [15:0] width_reg, height_reg;
    logic        interlaced_reg;

    // decoder state
    logic [31:0]        buf_reg, buf_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [7:0]         sub_left_reg, sub_left_next;
    logic               ended_reg, ended_next;
    logic [3:0]         cw_reg, cw_next;
    logic [DEPTH_W-1:0] nfc_reg, nfc_next;
    logic [ADDR_W-1:0]  prev_reg, prev_next;
    logic               await_reg, await_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [15:0]        col_reg, col_next;
    logic [15:0]        rows_reg, rows_next;
    logic [15:0]        drow_reg, drow_next;
    logic [1:0]         pass_reg, pass_next;
    logic               fin_reg, fin_next;
    logic [7:0]         byte_reg;
    logic [ADDR_W-1:0]  code_reg, code_next;
    logic [ADDR_W-1:0]  walk_reg, walk_next;
    logic               kwk_reg, kwk_next;
    logic [7:0]         root_reg, root_next;
    logic [7:0]         first_reg, first_next;

    // pending result
    logic [2:0]  rst_reg, rst_next;
    logic [7:0]  rpix_reg, rpix_next;
    logic [15:0] rcol_reg, rcol_next;
    logic [15:0] rrow_reg, rrow_next;
    logic        rend_reg, rend_next;

    // memories
    logic [19:0]       tbl_mem [TABLE_CODES];
    logic [7:0]        stk_mem [TABLE_CODES];
    logic [19:0]       tbl_q;
    logic [7:0]        stk_q;
    logic              tbl_we;
    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr;
    logic [7:0]        stk_wdata;

    // derived code values
    logic [3:0]         size_cl;
    logic [DEPTH_W-1:0] cc;
    logic [ADDR_W-1:0]  code_w;
    logic [31:0]        code_mask;
    logic [DEPTH_W-1:0] nfc_inc;
    logic               cfg_hit;

    // emit helpers
    logic [16:0] col_p1;
    logic [16:0] y_v;
    logic [1:0]  pass_v;
    logic [15:0] rows_p1;

    always_comb
    begin
        size_cl = min_size_reg;
        if (min_size_reg < 4'd2)
        begin
            size_cl = 4'd2;
        end
        else if (min_size_reg > 4'd11)
        begin
            size_cl = 4'd11;
        end
        cc        = DEPTH_W'(1) << size_cl;
        code_mask = (32'd1 << cw_reg) - 32'd1;
        code_w    = ADDR_W'(buf_reg & code_mask);
        nfc_inc   = nfc_reg + DEPTH_W'(1);
    end

    assign cfg_hit = cfg_valid && (cfg_index == CFG_MIN_CODE_SIZE
                     || cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT
                     || cfg_index == CFG_INTERLACED);

    always_comb
    begin
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        sub_left_next = sub_left_reg;
        ended_next    = ended_reg;
        cw_next       = cw_reg;
        nfc_next      = nfc_reg;
        prev_next     = prev_reg;
        await_next    = await_reg;
        depth_next    = depth_reg;
        col_next      = col_reg;
        rows_next     = rows_reg;
        drow_next     = drow_reg;
        pass_next     = pass_reg;
        fin_next      = fin_reg;
        code_next     = code_reg;
        walk_next     = walk_reg;
        kwk_next      = kwk_reg;
        root_next     = root_reg;
        first_next    = first_reg;
        rst_next      = rst_reg;
        rpix_next     = rpix_reg;
        rcol_next     = rcol_reg;
        rrow_next     = rrow_reg;
        rend_next     = rend_reg;
        tbl_we        = 1'b0;
        stk_we        = 1'b0;
        stk_waddr     = depth_reg[ADDR_W-1:0];
        stk_wdata     = root_reg;
        stat.chk      = CHK_DONE;
        stat.walk_read = ({1'b0, walk_reg} >= cc);
        stat.walk_more = (depth_reg < DEPTH_W'(TABLE_CODES - 1));
        stat.kwk       = kwk_reg;
        col_p1  = {1'b0, col_reg} + 17'd1;
        rows_p1 = rows_reg + 16'd1;
        y_v     = {1'b0, drow_reg} + 17'(pass_row_step(pass_reg));
        pass_v  = pass_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (y_v >= {1'b0, height_reg} && pass_v < 2'd3)
            begin
                pass_v = pass_v + 2'd1;
                y_v    = 17'(pass_first_row(pass_v));
            end
        end

        unique case (ctl.cmd)
            CMD_OFFER:
            begin
                rst_next  = ST_TAKEN;
                rpix_next = '0;
                rcol_next = '0;
                rrow_next = '0;
                rend_next = 1'b0;
                if (fin_reg)
                begin
                    rst_next = ST_TAKEN;
                end
                else if (ended_reg)
                begin
                    rst_next = ST_REFUSED;
                end
                else if (sub_left_reg == 8'd0)
                begin
                    if (byte_reg == 8'd0)
                    begin
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        sub_left_next = byte_reg;
                    end
                end
                else if (cnt_reg > 6'd24)
                begin
                    rst_next = ST_REFUSED;
                end
                else
                begin
                    buf_next      = buf_reg | ({24'd0, byte_reg} << cnt_reg);
                    cnt_next      = cnt_reg + 6'd8;
                    sub_left_next = sub_left_reg - 8'd1;
                end
            end
            CMD_CHECK:
            begin
                rpix_next = '0;
                rcol_next = '0;
                rrow_next = '0;
                rend_next = 1'b0;
                if (fin_reg || rows_reg >= height_reg)
                begin
                    fin_next   = 1'b1;
                    depth_next = '0;
                    rst_next   = ST_FRAME_END;
                    stat.chk   = CHK_DONE;
                end
                else if (depth_reg != '0)
                begin
                    stat.chk = CHK_PIXEL;
                end
                else if (cnt_reg < {2'b00, cw_reg})
                begin
                    stat.chk = CHK_DONE;
                    if (ended_reg)
                    begin
                        fin_next = 1'b1;
                        rst_next = ST_FRAME_END;
                    end
                    else
                    begin
                        rst_next = ST_NEED_DATA;
                    end
                end
                else
                begin
                    buf_next  = buf_reg >> cw_reg;
                    cnt_next  = cnt_reg - {2'b00, cw_reg};
                    code_next = code_w;
                    if ({1'b0, code_w} == cc)
                    begin
                        cw_next    = size_cl + 4'd1;
                        nfc_next   = cc + DEPTH_W'(2);
                        prev_next  = '0;
                        await_next = 1'b1;
                        stat.chk   = CHK_AGAIN;
                    end
                    else if ({1'b0, code_w} == cc + DEPTH_W'(1))
                    begin
                        fin_next   = 1'b1;
                        depth_next = '0;
                        rst_next   = ST_FRAME_END;
                        stat.chk   = CHK_DONE;
                    end
                    else if (!await_reg && {1'b0, code_w} == nfc_reg)
                    begin
                        kwk_next   = 1'b1;
                        depth_next = DEPTH_W'(1);
                        walk_next  = prev_reg;
                        stat.chk   = CHK_WALK;
                    end
                    else if ({1'b0, code_w} < cc || {1'b0, code_w} < nfc_reg)
                    begin
                        kwk_next   = 1'b0;
                        depth_next = '0;
                        walk_next  = code_w;
                        stat.chk   = CHK_WALK;
                    end
                    else
                    begin
                        fin_next   = 1'b1;
                        depth_next = '0;
                        rst_next   = ST_BAD_CODE;
                        stat.chk   = CHK_DONE;
                    end
                end
            end
            CMD_WALK_ADDR:
            begin
                if (!stat.walk_read)
                begin
                    root_next = walk_reg[7:0];
                end
            end
            CMD_WALK_DATA:
            begin
                if (stat.walk_more)
                begin
                    stk_we     = 1'b1;
                    stk_wdata  = tbl_q[7:0];
                    depth_next = depth_reg + DEPTH_W'(1);
                    walk_next  = tbl_q[19:8];
                end
                else
                begin
                    root_next = tbl_q[7:0];
                end
            end
            CMD_ROOT:
            begin
                stk_we     = 1'b1;
                depth_next = depth_reg + DEPTH_W'(1);
                first_next = root_reg;
            end
            CMD_KWK:
            begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = first_reg;
            end
            CMD_TABLE:
            begin
                if (!await_reg && nfc_reg < DEPTH_W'(TABLE_CODES))
                begin
                    tbl_we   = 1'b1;
                    nfc_next = nfc_inc;
                    if (nfc_inc >= (DEPTH_W'(1) << cw_reg)
                        && cw_reg < 4'(MAX_CODE_BITS))
                    begin
                        cw_next = cw_reg + 4'd1;
                    end
                end
                await_next = 1'b0;
                prev_next  = code_reg;
            end
            CMD_EMIT:
            begin
                depth_next = depth_reg - DEPTH_W'(1);
                rst_next   = ST_PIXEL;
                rpix_next  = stk_q;
                rcol_next  = col_reg;
                rrow_next  = drow_reg;
                rend_next  = 1'b0;
                if (col_p1 >= {1'b0, width_reg})
                begin
                    rend_next = 1'b1;
                    col_next  = '0;
                    rows_next = rows_p1;
                    if (interlaced_reg)
                    begin
                        pass_next = pass_v;
                        drow_next = y_v[15:0];
                    end
                    else
                    begin
                        drow_next = drow_reg + 16'd1;
                    end
                    if (rows_p1 >= height_reg)
                    begin
                        fin_next   = 1'b1;
                        depth_next = '0;
                    end
                end
                else
                begin
                    col_next = col_p1[15:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // string table and pixel stack
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[nfc_reg[ADDR_W-1:0]] <= {prev_reg, first_reg};
        end
        tbl_q <= tbl_mem[walk_reg];
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_q <= stk_mem[depth_reg[ADDR_W-1:0] - ADDR_W'(1)];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            byte_reg <= in_byte;
        end
        code_reg  <= code_next;
        walk_reg  <= walk_next;
        kwk_reg   <= kwk_next;
        root_reg  <= root_next;
        first_reg <= first_next;
        rst_reg   <= rst_next;
        rpix_reg  <= rpix_next;
        rcol_reg  <= rcol_next;
        rrow_reg  <= rrow_next;
        rend_reg  <= rend_next;
        if (ctl.out_load)
        begin
            status      <= rst_reg;
            pixel_index <= rpix_reg;
            column      <= rcol_reg;
            display_row <= rrow_reg;
            row_end     <= rend_reg;
        end
    end

    // configuration and decoder control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg   <= 4'd8;
            width_reg      <= 16'd1;
            height_reg     <= 16'd1;
            interlaced_reg <= 1'b0;
            buf_reg        <= '0;
            cnt_reg        <= '0;
            sub_left_reg   <= '0;
            ended_reg      <= 1'b0;
            cw_reg         <= 4'd9;
            nfc_reg        <= DEPTH_W'(258);
            prev_reg       <= '0;
            await_reg      <= 1'b1;
            depth_reg      <= '0;
            col_reg        <= '0;
            rows_reg       <= '0;
            drow_reg       <= '0;
            pass_reg       <= '0;
            fin_reg        <= 1'b0;
        end
        else if (cfg_hit)
        begin
            priority case (cfg_index)
                CFG_MIN_CODE_SIZE:
                begin
                    min_size_reg <= cfg_data[3:0];
                    if (cfg_data[3:0] < 4'd2)
                    begin
                        cw_reg  <= 4'd3;
                        nfc_reg <= DEPTH_W'(6);
                    end
                    else if (cfg_data[3:0] > 4'd11)
                    begin
                        cw_reg  <= 4'd12;
                        nfc_reg <= DEPTH_W'(2050);
                    end
                    else
                    begin
                        cw_reg  <= cfg_data[3:0] + 4'd1;
                        nfc_reg <= (DEPTH_W'(1) << cfg_data[3:0]) + DEPTH_W'(2);
                    end
                end
                CFG_FRAME_WIDTH:
                begin
                    width_reg <= cfg_data;
                    cw_reg    <= size_cl + 4'd1;
                    nfc_reg   <= cc + DEPTH_W'(2);
                end
                CFG_FRAME_HEIGHT:
                begin
                    height_reg <= cfg_data;
                    cw_reg     <= size_cl + 4'd1;
                    nfc_reg    <= cc + DEPTH_W'(2);
                end
                default:
                begin
                    interlaced_reg <= cfg_data[0];
                    cw_reg         <= size_cl + 4'd1;
                    nfc_reg        <= cc + DEPTH_W'(2);
                end
            endcase
            buf_reg      <= '0;
            cnt_reg      <= '0;
            sub_left_reg <= '0;
            ended_reg    <= 1'b0;
            prev_reg     <= '0;
            await_reg    <= 1'b1;
            depth_reg    <= '0;
            col_reg      <= '0;
            rows_reg     <= '0;
            drow_reg     <= '0;
            pass_reg     <= '0;
            fin_reg      <= 1'b0;
        end
        else
        begin
            buf_reg      <= buf_next;
            cnt_reg      <= cnt_next;
            sub_left_reg <= sub_left_next;
            ended_reg    <= ended_next;
            cw_reg       <= cw_next;
            nfc_reg      <= nfc_next;
            prev_reg     <= prev_next;
            await_reg    <= await_next;
            depth_reg    <= depth_next;
            col_reg      <= col_next;
            rows_reg     <= rows_next;
            drow_reg     <= drow_next;
            pass_reg     <= pass_next;
            fin_reg      <= fin_next;
        end
    end

endmodule

// ----- rtl/gif_lzw_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// gif_lzw_pixel_decoder
// lzw decoder for gif image data with sub-block deframing and interlace order
// ----------------------------------------------------------------------------
// Feed the raw image-data bytes (length bytes included) as offer items and
// pull pixels with pull items; every item gives exactly one result item. One
// item is in work at a time. An offer runs the offer step. A pull popping a
// pixel already on the stack runs the check, read and emit steps; a pull
// that decodes a new code also walks its prefix chain, one registered read
// of the string table per link, pushes the root (and, for a code not yet in
// the table, the prior string's first pixel) and updates the table. A clear
// code repeats the check step. A result that waits on the output stalls the
// next item in its last step. A code string is expanded once into the pixel
// stack and then popped one pixel per pull. A configuration write restarts
// the frame and is taken only while no item is in work. The string table and
// the stack hold no reset value; the stream itself fills them.
// ----------------------------------------------------------------------------
module gif_lzw_pixel_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    // item in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] opcode: 0 offer byte, 1 pull pixel
    // item out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] pixel_index, [23:8] column, [39:24] display_row
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast,   // row_end
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import glzw_pkg::*;

    ctl_t     ctl;
    dp_stat_t stat;

    // configuration writes are taken only while no item is in work
    assign cfg_ready = s_tready;

    glzw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl),
        .stat     (stat)
    );

    glzw_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .in_byte     (s_tdata),
        .cfg_valid   (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (m_tuser),
        .pixel_index (m_tdata[7:0]),
        .column      (m_tdata[23:8]),
        .display_row (m_tdata[39:24]),
        .row_end     (m_tlast)
    );

endmodule

// ----- verif/glzw_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_tb_pkg
// item opcodes shared by the decoder testbench and its checker
// ----------------------------------------------------------------------------
package glzw_tb_pkg;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_PULL  = 1'b1;

endpackage

// ----- verif/glzw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_checker
// watches the decoder channels, predicts each result item and compares it
// ----------------------------------------------------------------------------
module glzw_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);
    import glzw_pkg::*;
    import glzw_tb_pkg::*;

    typedef struct packed {
        res_status_t status;
        logic [7:0]  pixel;
        logic [15:0] col;
        logic [15:0] row;
        logic        row_end;
    } pixel_result_t;

    localparam int unsigned FIRST_ROW [4] = '{0, 4, 2, 1};
    localparam int unsigned ROW_STEP  [4] = '{8, 8, 4, 2};

    logic [3:0]  min_size;
    logic [15:0] width_px;
    logic [15:0] height_rows;
    logic        interlace_on;

    logic [11:0] prefix_mem  [TABLE_CODES];
    logic [7:0]  suffix_mem  [TABLE_CODES];
    logic [7:0]  pixel_stack [TABLE_CODES];
    logic [12:0] stack_top;
    logic [31:0] bit_buf;
    logic [5:0]  bit_cnt;
    logic [7:0]  block_left;
    logic        stream_end;
    logic [3:0]  code_w;
    logic [12:0] free_code;
    logic [11:0] prev_code;
    logic        await_first;
    logic [15:0] col_pos;
    logic [15:0] rows_out;
    logic [15:0] disp_row;
    logic [1:0]  pass_no;
    logic        frame_done;

    pixel_result_t expected_q[$];
    pixel_result_t want;
    logic [39:0]   got_data;

    function automatic int unsigned eff_size();
        int unsigned s;
        s = min_size;
        if (s < 2) s = 2;
        if (s > 11) s = 11;
        return s;
    endfunction

    function automatic void restart_codes();
        code_w      = 4'(eff_size() + 1);
        free_code   = 13'((32'd1 << eff_size()) + 2);
        prev_code   = '0;
        await_first = 1'b1;
    endfunction

    function automatic void new_frame();
        stack_top  = '0;
        bit_buf    = '0;
        bit_cnt    = '0;
        block_left = '0;
        stream_end = 1'b0;
        restart_codes();
        col_pos    = '0;
        rows_out   = '0;
        disp_row   = '0;
        pass_no    = '0;
        frame_done = 1'b0;
    endfunction

    function automatic void end_frame();
        frame_done = 1'b1;
        stack_top  = '0;
    endfunction

    // string of code c onto the stack, first pixel on top; returns that pixel
    function automatic logic [7:0] expand_code(input int unsigned c, input int unsigned start);
        int unsigned cc;
        int unsigned d;
        logic [7:0]  root;
        cc = 32'd1 << eff_size();
        d  = start;
        c  = c & (TABLE_CODES - 1);
        while (c >= cc && d < TABLE_CODES - 1) begin
            pixel_stack[d] = suffix_mem[c];
            d++;
            c = prefix_mem[c];
        end
        root = (c >= cc) ? suffix_mem[c] : c[7:0];
        pixel_stack[d] = root;
        stack_top = 13'(d + 1);
        return root;
    endfunction

    function automatic pixel_result_t pop_pixel();
        pixel_result_t r;
        int unsigned   y;
        r = '0;
        r.status  = ST_PIXEL;
        stack_top = stack_top - 1;
        r.pixel   = pixel_stack[stack_top[11:0]];
        r.col     = col_pos;
        r.row     = disp_row;
        if (32'(col_pos) + 1 >= 32'(width_px)) begin
            r.row_end = 1'b1;
            col_pos   = '0;
            rows_out  = rows_out + 1;
            if (interlace_on) begin
                y = 32'(disp_row) + ROW_STEP[pass_no];
                while (y >= height_rows && pass_no < 3) begin
                    pass_no = pass_no + 1;
                    y = FIRST_ROW[pass_no];
                end
                disp_row = y[15:0];
            end
            else begin
                disp_row = disp_row + 1;
            end
            if (rows_out >= height_rows) end_frame();
        end
        else begin
            col_pos = col_pos + 1;
        end
        return r;
    endfunction

    function automatic pixel_result_t pull_item();
        pixel_result_t r;
        int unsigned   cc;
        int unsigned   code;
        logic [7:0]    lead;
        r  = '0;
        cc = 32'd1 << eff_size();
        if (!frame_done && rows_out >= height_rows) end_frame();
        if (frame_done) begin
            r.status = ST_FRAME_END;
            return r;
        end
        while (stack_top == 0) begin
            if (bit_cnt < code_w) begin
                if (stream_end) begin
                    end_frame();
                    r.status = ST_FRAME_END;
                end
                else begin
                    r.status = ST_NEED_DATA;
                end
                return r;
            end
            code    = bit_buf & ((32'd1 << code_w) - 1);
            bit_buf = bit_buf >> code_w;
            bit_cnt = bit_cnt - code_w;
            if (code == cc) begin
                restart_codes();
                continue;
            end
            if (code == cc + 1) begin
                end_frame();
                r.status = ST_FRAME_END;
                return r;
            end
            // code not yet in the table: previous string plus its own first pixel
            if (!await_first && code == free_code) begin
                lead = expand_code(prev_code, 1);
                pixel_stack[0] = lead;
            end
            else if (code < cc || code < free_code) begin
                lead = expand_code(code, 0);
            end
            else begin
                end_frame();
                r.status = ST_BAD_CODE;
                return r;
            end
            if (!await_first && free_code < TABLE_CODES) begin
                prefix_mem[free_code[11:0]] = prev_code;
                suffix_mem[free_code[11:0]] = lead;
                free_code = free_code + 1;
                if (32'(free_code) >= (32'd1 << code_w) && code_w < MAX_CODE_BITS)
                    code_w = code_w + 1;
            end
            await_first = 1'b0;
            prev_code   = code[11:0];
        end
        return pop_pixel();
    endfunction

    function automatic pixel_result_t offer_item(input logic [7:0] b);
        pixel_result_t r;
        r = '0;
        r.status = ST_TAKEN;
        if (frame_done) return r;
        if (stream_end) begin
            r.status = ST_REFUSED;
            return r;
        end
        if (block_left == 0) begin
            if (b == 0) stream_end = 1'b1;
            else block_left = b;
            return r;
        end
        if (bit_cnt > 24) begin
            r.status = ST_REFUSED;
            return r;
        end
        bit_buf    = bit_buf | (32'(b) << bit_cnt);
        bit_cnt    = bit_cnt + 8;
        block_left = block_left - 1;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_size     = 4'd8;
            width_px     = 16'd1;
            height_rows  = 16'd1;
            interlace_on = 1'b0;
            for (int i = 0; i < TABLE_CODES; i++) begin
                prefix_mem[i]  = '0;
                suffix_mem[i]  = '0;
                pixel_stack[i] = '0;
            end
            new_frame();
            expected_q.delete();
            errors  = 0;
            pending = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report($sformatf("result item with none expected, status %0d", m_tuser));
                end
                else begin
                    want     = expected_q.pop_front();
                    got_data = m_tdata;
                    if (m_tuser != want.status)
                        report($sformatf("status %0d, want %0d", m_tuser, want.status));
                    if (got_data[7:0] != want.pixel)
                        report($sformatf("pixel %0d, want %0d", got_data[7:0], want.pixel));
                    if (got_data[23:8] != want.col)
                        report($sformatf("column %0d, want %0d", got_data[23:8], want.col));
                    if (got_data[39:24] != want.row)
                        report($sformatf("row %0d, want %0d", got_data[39:24], want.row));
                    if (m_tlast != want.row_end)
                        report($sformatf("row end %0b, want %0b", m_tlast, want.row_end));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_CODE_SIZE: min_size     = cfg_data[3:0];
                    CFG_FRAME_WIDTH:   width_px     = cfg_data;
                    CFG_FRAME_HEIGHT:  height_rows  = cfg_data;
                    CFG_INTERLACED:    interlace_on = cfg_data[0];
                    default: ;
                endcase
                if (cfg_index <= CFG_INTERLACED) new_frame();
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_PULL) expected_q.push_back(pull_item());
                else expected_q.push_back(offer_item(s_tdata));
            end
            pending = expected_q.size();
        end
    end

endmodule

// ----- verif/tb_gif_lzw_pixel_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gif_lzw_pixel_decoder
// stimulus for the gif lzw pixel decoder: builds lzw code streams, frames them
// into sub-blocks and feeds them as offer items interleaved with pull items,
// under several idle/stall mixes; a checker module predicts and compares
// ----------------------------------------------------------------------------
module tb_gif_lzw_pixel_decoder;
    import glzw_pkg::*;
    import glzw_tb_pkg::*;

    localparam int LIMIT        = 1500000;  // cycles before the run is declared hung
    localparam int RANDOM_ITEMS = 1550;
    localparam int HOLD_CYCLES  = 300;

    // kinds of generated code stream
    localparam int KIND_CLEAN = 0;  // well-formed codes with random content
    localparam int KIND_NOISE = 1;  // any code of the current width
    localparam int KIND_ROOTS = 2;  // roots only until the string table is full

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int chk_errors;
    int chk_pending;

    // handshake bookkeeping seen from the stimulus side
    int   cycles        = 0;
    int   n_sent        = 0;
    int   n_recv        = 0;
    logic op_q[$];
    logic last_op;
    bit   offer_busy    = 0;
    bit   offer_refused = 0;
    bit   frame_over    = 0;

    // idle mix and the one long receiver hold-off
    int send_idle = 0;
    int stall_pct = 0;
    bit hold_req  = 0;
    bit hold_done = 0;
    int hold_left = 0;

    // generated stream
    logic [7:0]      payload_q[$];
    logic [7:0]      byte_q[$];
    longint unsigned acc;
    int              nacc;

    gif_lzw_pixel_decoder i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    glzw_checker i_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (chk_errors),
        .pending   (chk_pending)
    );

    always #6 clk = ~clk;

    // hang guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result side: match each result item to the opcode that caused it
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_recv <= n_recv + 1;
            if (op_q.size() != 0)
            begin
                last_op = op_q.pop_front();
                if (last_op == OP_OFFER)
                begin
                    offer_busy    <= 1'b0;
                    offer_refused <= (m_tuser == ST_REFUSED);
                end
            end
            if (m_tuser == ST_FRAME_END || m_tuser == ST_BAD_CODE)
                frame_over <= 1'b1;
        end
    end

    // one item on the input channel, with random gaps ahead of it
    task automatic send_item(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        op_q.push_back(op);
        n_sent++;
        if (op == OP_OFFER)
            offer_busy = 1'b1;
    endtask

    // sender stops until every result item has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (n_sent != n_recv)
            @(posedge clk);
    endtask

    // register write; valid stays high across back-to-back writes
    task automatic cfg_write(input logic [7:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // lsb-first code packing
    task automatic pack_code(input int unsigned code, input int unsigned w);
        acc  = acc | (longint'(code) << nacc);
        nacc = nacc + w;
        while (nacc >= 8)
        begin
            payload_q.push_back(acc[7:0]);
            acc  = acc >> 8;
            nacc = nacc - 8;
        end
    endtask

    // lzw code stream framed into sub-blocks, mirroring the decoder's width growth
    task automatic build_stream(input int unsigned size_reg, input int n_codes, input int kind);
        int unsigned s;
        int unsigned cc;
        int unsigned w;
        int unsigned nf;
        int unsigned code;
        int          pos;
        int          len;
        bit          fresh;
        s = size_reg;
        if (s < 2) s = 2;
        if (s > 11) s = 11;
        cc = 1 << s;
        w = s + 1;
        nf = cc + 2;
        fresh = 1;
        payload_q.delete();
        byte_q.delete();
        acc = 0;
        nacc = 0;
        pack_code(cc, w);
        for (int i = 0; i < n_codes; i++)
        begin
            if (kind != KIND_ROOTS && $urandom_range(99) < 3)
            begin
                // clear code mid-stream
                pack_code(cc, w);
                w = s + 1;
                nf = cc + 2;
                fresh = 1;
                continue;
            end
            if (kind == KIND_NOISE)
                code = $urandom_range((1 << w) - 1);
            else if (fresh || (kind == KIND_ROOTS && nf < TABLE_CODES))
                code = $urandom_range(cc - 1);
            else if ($urandom_range(99) < 15 && nf < TABLE_CODES)
                code = nf;  // the code about to be defined
            else
            begin
                code = $urandom_range(nf - 1);
                if (code == cc || code == cc + 1)
                    code = $urandom_range(cc - 1);
            end
            pack_code(code, w);
            if (!fresh && nf < TABLE_CODES)
            begin
                nf++;
                if (nf >= (1 << w) && w < MAX_CODE_BITS)
                    w++;
            end
            fresh = 0;
        end
        // end-of-information usually, else the stream just runs out
        if ($urandom_range(9) != 0)
            pack_code(cc + 1, w);
        if (nacc > 0)
            payload_q.push_back(acc[7:0]);
        pos = 0;
        while (pos < payload_q.size())
        begin
            len = ($urandom_range(9) == 0) ? 255 : $urandom_range(1, 24);
            if (len > payload_q.size() - pos)
                len = payload_q.size() - pos;
            byte_q.push_back(8'(len));
            for (int k = 0; k < len; k++)
                byte_q.push_back(payload_q[pos + k]);
            pos = pos + len;
        end
        byte_q.push_back(8'd0);
    endtask

    // one frame: configure while idle, then interleave offers and pulls
    task automatic run_frame(input int mcs, input int fw, input int fh, input int il,
                             input int n_codes, input int kind, input int pull_pct);
        int idx;
        int tries;
        int pulls;
        bit waiting;
        bit junk_done;
        drain();
        repeat (3) @(posedge clk);
        cfg_write(CFG_MIN_CODE_SIZE, 16'(mcs));
        cfg_write(CFG_FRAME_WIDTH, 16'(fw));
        cfg_write(CFG_FRAME_HEIGHT, 16'(fh));
        cfg_write(CFG_INTERLACED, 16'(il));
        cfg_valid <= 1'b0;
        frame_over = 1'b0;
        build_stream(mcs, n_codes, kind);
        idx = 0;
        tries = 0;
        pulls = 0;
        waiting = 0;
        junk_done = 0;
        while (1)
        begin
            // only one offer in flight, so a refused byte can be sent again in order
            if (waiting && !offer_busy)
            begin
                waiting = 0;
                if (offer_refused && tries < 6 && idx < byte_q.size())
                    tries++;
                else
                begin
                    idx++;
                    tries = 0;
                end
            end
            if (idx >= byte_q.size() && !waiting && (frame_over || pulls > 6000))
                break;
            if ($urandom_range(299) == 0)
                drain();
            else if (idx < byte_q.size() && !waiting &&
                     (frame_over || $urandom_range(99) >= pull_pct))
            begin
                send_item(OP_OFFER, byte_q[idx]);
                waiting = 1;
            end
            else if (idx == byte_q.size() && !waiting && !junk_done &&
                     $urandom_range(7) == 0)
            begin
                // stray byte after the terminator
                send_item(OP_OFFER, 8'($urandom));
                waiting = 1;
                junk_done = 1;
            end
            else if (!frame_over)
            begin
                send_item(OP_PULL, 8'($urandom));
                pulls++;
            end
            else
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        // bytes after the frame is done are taken and dropped
        if ($urandom_range(1) == 0)
            send_item(OP_OFFER, 8'($urandom));
    endtask

    function automatic int pick_dim();
        int r;
        r = $urandom_range(19);
        if (r == 0) return 0;
        if (r == 1) return 65535;
        if (r == 2) return $urandom_range(65535);
        return $urandom_range(1, 9);
    endfunction

    initial
    begin
        int base;
        int frame_no;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames
        run_frame(2, 3, 2, 0, 6, KIND_CLEAN, 40);
        run_frame(0, 0, 3, 0, 5, KIND_CLEAN, 50);   // size below range, zero width
        run_frame(15, 4, 0, 1, 2, KIND_CLEAN, 50);  // size above range, zero height
        run_frame(3, 1, 9, 1, 12, KIND_CLEAN, 50);  // interlaced, every pass used

        // random frames under rotating idle mixes
        base = n_sent;
        frame_no = 0;
        while (n_sent - base < RANDOM_ITEMS)
        begin
            case (frame_no % 5)
                1: begin send_idle = 68; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 68; end
                3: begin send_idle = 34; stall_pct = 34; end
                default: begin send_idle = 0; stall_pct = 0; end
            endcase
            if (frame_no == 3)
                hold_req = 1;
            run_frame($urandom_range(7) == 0 ? $urandom_range(15) : $urandom_range(2, 8),
                      pick_dim(), pick_dim(), $urandom_range(1), $urandom_range(3, 40),
                      $urandom_range(99) < 15 ? KIND_NOISE : KIND_CLEAN,
                      $urandom_range(20, 75));
            frame_no++;
        end

        // fill the string table to its last entry and keep decoding past it
        send_idle = 0;
        stall_pct = 0;
        run_frame(11, 65535, 65535, 0, 2100, KIND_ROOTS, 50);

        drain();
        repeat (40) @(posedge clk);
        if (chk_errors == 0 && chk_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
